>>> rtl/page_bitmap_allocator_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PBA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/pba_pkg.sv
// Package of shared types and constants for the page bitmap allocator.
`timescale 1ns / 1ps
package pba_pkg;
  localparam int unsigned POOL_PAGES_DEF = 1024;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned AVAIL_W = 23;
  localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_W = 136;
  localparam int unsigned OUT_W = 152;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE = 2'd1,
    REQ_SHRINK = 2'd2,
    REQ_BAD = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_POOL_PAGES = 2'd0,
    CFG_PHYS_BASE = 2'd1,
    CFG_VIRT_BASE = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FLIP,
    ST_DONE,
    ST_CLEAR
  } state_t;

  // Scan unit sequencer states
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_READ,
    SC_TEST,
    SC_FLIP,
    SC_CLEAR
  } scan_state_t;

  // Scan unit control and status
  typedef struct packed {
    logic start;
    logic want;
  } scan_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } scan_sts_t;
endpackage

>>> rtl/pba_scan.sv
// Run search and flip unit; it reads, then tests, each map page.
`timescale 1ns / 1ps
module pba_scan #(
  parameter int unsigned POOL_PAGES = pba_pkg::POOL_PAGES_DEF,
  localparam int unsigned IW = $clog2(POOL_PAGES),
  localparam int unsigned CW = IW + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  pba_pkg::scan_ctl_t ctl,
  input  logic [CW-1:0]      run_len,
  input  logic [CW-1:0]      from,
  input  logic [CW-1:0]      pages,
  input  logic               clear_all,
  output pba_pkg::scan_sts_t sts,
  output logic [CW-1:0]      run_start
);
  logic used_mem [POOL_PAGES];
  pba_pkg::scan_state_t sc, sc_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] run;
  logic pass;
  logic rd;
  logic found;
  logic done;
  logic want;
  logic [CW-1:0] flip_left;
  logic hit, last_hit, at_end, fail_now, hit_now;

  // Registered map read
  always_ff @(posedge clk) begin
    rd <= used_mem[idx[IW-1:0]];
    if (sc == pba_pkg::SC_FLIP) begin
      used_mem[idx[IW-1:0]] <= ~want;
    end else if (sc == pba_pkg::SC_CLEAR) begin
      used_mem[idx[IW-1:0]] <= 1'b0;
    end
  end

  // Page test against the wanted state
  assign hit = (rd == want);
  assign last_hit = hit && (run + CW'(1) == run_len);
  assign at_end = (idx + CW'(1) >= pages);

  // Next state
  always_comb begin
    sc_next = sc;
    unique case (sc)
      pba_pkg::SC_IDLE: begin
        if (clear_all) sc_next = pba_pkg::SC_CLEAR;
        else if (ctl.start) sc_next = pba_pkg::SC_READ;
      end
      pba_pkg::SC_READ: sc_next = pba_pkg::SC_TEST;
      pba_pkg::SC_TEST: begin
        if (last_hit) sc_next = pba_pkg::SC_FLIP;
        else if (at_end && pass) sc_next = pba_pkg::SC_IDLE;
        else sc_next = pba_pkg::SC_READ;
      end
      pba_pkg::SC_FLIP: if (flip_left == CW'(1)) sc_next = pba_pkg::SC_IDLE;
      pba_pkg::SC_CLEAR: if (idx == CW'(POOL_PAGES - 1)) sc_next = pba_pkg::SC_IDLE;
      default: sc_next = pba_pkg::SC_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    fail_now = (sc == pba_pkg::SC_TEST) && !last_hit && at_end && pass;
    hit_now = (sc == pba_pkg::SC_FLIP) && (flip_left == CW'(1));
    sts.busy = (sc != pba_pkg::SC_IDLE);
    sts.done = done;
    sts.found = found;
  end

  // Search datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      sc <= pba_pkg::SC_CLEAR;
      idx <= '0;
      done <= 1'b0;
      found <= 1'b0;
    end else begin
      sc <= sc_next;
      done <= fail_now || hit_now;
      if (fail_now || hit_now) found <= hit_now;
      unique case (sc)
        pba_pkg::SC_IDLE: begin
          if (clear_all) begin
            idx <= '0;
          end else if (ctl.start) begin
            want <= ctl.want;
            run <= '0;
            if (from >= pages) begin
              idx <= '0;
              pass <= 1'b1;
            end else begin
              idx <= from;
              pass <= 1'b0;
            end
          end
        end
        pba_pkg::SC_READ: ;
        pba_pkg::SC_TEST: begin
          if (last_hit) begin
            run_start <= idx + CW'(1) - run_len;
            idx <= idx + CW'(1) - run_len;
            flip_left <= run_len;
          end else if (at_end) begin
            // Wrap to page 0 once
            if (!pass) begin
              pass <= 1'b1;
              run <= '0;
              idx <= '0;
            end
          end else begin
            run <= hit ? run + CW'(1) : '0;
            idx <= idx + CW'(1);
          end
        end
        pba_pkg::SC_FLIP: begin
          idx <= idx + CW'(1);
          flip_left <= flip_left - CW'(1);
        end
        pba_pkg::SC_CLEAR: begin
          if (idx == CW'(POOL_PAGES - 1)) idx <= '0;
          else idx <= idx + CW'(1);
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/page_bitmap_allocator_unit.sv
// Top level of the page bitmap allocator.
// Slave channel s_axis_* takes one request item; master channel m_axis_*
// returns exactly one result item per request.
// Configuration goes through cfg_we / cfg_idx / cfg_data while idle;
// writing pool_pages clears the map, the hint and the free count.
// After a check state, each page visited by the run search goes through a
// read state and a test state (the single-ported map memory is read once
// per page), and each page flipped goes through a flip state.
// One item is in work at a time; s_axis_tready is low meanwhile.
// After reset, and after a pool_pages write, a clearing pass runs through
// all POOL_PAGES map entries; no item is accepted during it.
// A finished result is held in an output register until m_axis_tready;
// the next item is taken only once the result has left.
// free and shrink addresses are converted to page indexes by a shift.
`timescale 1ns / 1ps
module page_bitmap_allocator_unit #(
  parameter int unsigned POOL_PAGES = pba_pkg::POOL_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // req_type[1:0], address[65:2], size_bytes[97:66], target_bytes[129:98]
  input  logic [pba_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // ok[0], phys_addr[64:1], virt_addr[128:65], available_bytes[151:129]
  output logic [pba_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pba_pkg::CFG_W-1:0]    cfg_data
);
  localparam int unsigned IW = $clog2(POOL_PAGES);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned PS = $clog2(PAGE_BYTES);
  localparam int unsigned AW = pba_pkg::AVAIL_W;

  pba_pkg::state_t st, st_next;
  logic [10:0] pool_pages;
  logic [63:0] phys_base, virt_base;
  logic [CW-1:0] hint, pages, cap_pages;
  logic [AW-1:0] free_b, cap_b;
  logic [1:0] req;
  logic [63:0] addr;
  logic [32:0] size_r, tgt_r, chg;
  logic [63:0] hint64;
  logic [CW-1:0] run_len, run_start, from;
  logic ok;
  logic [63:0] pa, va;
  logic start_go, want;
  logic reinit;
  pba_pkg::scan_ctl_t ctl;
  pba_pkg::scan_sts_t sts;
  logic [33:0] sum;
  logic [63:0] off;

  // Live page count and capacity
  assign pages = (32'(pool_pages) > POOL_PAGES) ? CW'(POOL_PAGES) : CW'(pool_pages);
  assign cap_pages = pages;
  always_comb begin
    logic [63:0] c;
    c = 64'(cap_pages) << PS;
    cap_b = (c > 64'(pba_pkg::AVAIL_MAX)) ? pba_pkg::AVAIL_MAX : AW'(c);
  end

  assign reinit = cfg_we && cfg_idx == pba_pkg::CFG_POOL_PAGES;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pages <= 11'd1024;
      phys_base <= '0;
      virt_base <= '0;
    end else if (cfg_we) begin
      unique case (pba_pkg::cfg_idx_t'(cfg_idx))
        pba_pkg::CFG_POOL_PAGES: pool_pages <= cfg_data[10:0];
        pba_pkg::CFG_PHYS_BASE:  phys_base <= cfg_data;
        pba_pkg::CFG_VIRT_BASE:  virt_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // Run length and search hint for the request
  always_comb begin
    chg = size_r;
    hint64 = 64'(hint);
    unique case (pba_pkg::req_t'(req))
      pba_pkg::REQ_ALLOC:  hint64 = 64'(hint);
      pba_pkg::REQ_FREE:   hint64 = (addr - virt_base) >> PS;
      pba_pkg::REQ_SHRINK: begin
        chg = size_r - tgt_r;
        hint64 = (addr - virt_base + 64'(tgt_r)) >> PS;
      end
      default: ;
    endcase
    from = (hint64 < 64'(pages)) ? CW'(hint64) : '0;
  end

  always_comb begin
    logic [32:0] n;
    n = chg >> PS;
    run_len = (n > 33'(pages)) ? '0 : CW'(n);
  end

  assign want = (req != pba_pkg::REQ_ALLOC);
  assign ctl.start = start_go;
  assign ctl.want = want;

  pba_scan #(.POOL_PAGES(POOL_PAGES)) u_scan (
    .clk(clk), .rst(rst), .ctl(ctl), .run_len(run_len), .from(from),
    .pages(pages), .clear_all(reinit), .sts(sts), .run_start(run_start)
  );

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      pba_pkg::ST_CLEAR: if (!sts.busy) st_next = pba_pkg::ST_IDLE;
      pba_pkg::ST_IDLE: begin
        if (reinit) st_next = pba_pkg::ST_CLEAR;
        else if (s_axis_tvalid) st_next = pba_pkg::ST_CHECK;
      end
      pba_pkg::ST_CHECK: begin
        if (start_go) st_next = pba_pkg::ST_SCAN;
        else st_next = pba_pkg::ST_DONE;
      end
      pba_pkg::ST_SCAN: if (sts.done) st_next = pba_pkg::ST_FLIP;
      pba_pkg::ST_FLIP: st_next = pba_pkg::ST_DONE;
      pba_pkg::ST_DONE: if (m_axis_tready) st_next = pba_pkg::ST_IDLE;
      default: st_next = pba_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    start_go = 1'b0;
    if (st == pba_pkg::ST_CHECK && run_len != '0) begin
      unique case (pba_pkg::req_t'(req))
        pba_pkg::REQ_ALLOC:  start_go = size_r <= 33'(free_b);
        pba_pkg::REQ_FREE:   start_go = 1'b1;
        pba_pkg::REQ_SHRINK: start_go = tgt_r < size_r;
        default:             start_go = 1'b0;
      endcase
    end
  end
  assign s_axis_tready = (st == pba_pkg::ST_IDLE) && !reinit;
  assign m_axis_tvalid = (st == pba_pkg::ST_DONE);
  assign sum = 34'(free_b) + 34'(chg);
  assign off = 64'(run_start) << PS;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= pba_pkg::ST_CLEAR;
      hint <= '0;
      free_b <= cap_b;
      ok <= 1'b0;
    end else begin
      st <= st_next;
      if (st == pba_pkg::ST_IDLE && s_axis_tvalid && s_axis_tready) begin
        req <= s_axis_tdata[1:0];
        addr <= s_axis_tdata[65:2];
        size_r <= {1'b0, s_axis_tdata[97:66]};
        tgt_r <= {1'b0, s_axis_tdata[129:98]};
        ok <= 1'b0;
        pa <= '0;
        va <= '0;
      end
      if (reinit) begin
        hint <= '0;
        free_b <= cap_b;
      end else if (st == pba_pkg::ST_CLEAR) begin
        // Load the capacity of the new pool size
        free_b <= cap_b;
      end else if (st == pba_pkg::ST_FLIP && sts.found) begin
        // Commit on a found run
        ok <= 1'b1;
        if (req == pba_pkg::REQ_ALLOC) begin
          hint <= run_start + run_len;
          free_b <= free_b - AW'(size_r);
          pa <= phys_base + off;
          va <= virt_base + off;
        end else begin
          hint <= run_start;
          free_b <= (sum > 34'(cap_b)) ? cap_b : AW'(sum);
        end
      end
    end
  end

  assign m_axis_tdata = {free_b, va, pa, ok};
endmodule

>>> rtl/pba_checker.sv
// Port-level checker for the page bitmap allocator, bound to the top level.
`timescale 1ns / 1ps
`include "page_bitmap_allocator_unit_defines.svh"
module pba_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [pba_pkg::OUT_W-1:0] m_axis_tdata
);
  `PBA_ASSERT_IMPL(a_no_take_while_out, clk, rst, m_axis_tvalid, !s_axis_tready, "ready while result pending")
  `PBA_ASSERT_NEXT(a_busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "took two items")
  `PBA_ASSERT_IMPL(a_fail_zero_addr, clk, rst, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[128:1] == '0, "address on failure")
  `PBA_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

>>> test/tb_page_bitmap_allocator_unit.sv
// Testbench for page_bitmap_allocator_unit: directed and random requests checked by a predictor.
`timescale 1ns / 1ps
module tb_page_bitmap_allocator_unit;
  localparam int unsigned MAP_PAGES = pba_pkg::POOL_PAGES_DEF;
  localparam int unsigned PG_BYTES = pba_pkg::PAGE_BYTES_DEF;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct {
    pba_pkg::req_t kind;
    logic [63:0]   addr;
    logic [31:0]   size;
    logic [31:0]   target;
  } request_t;

  typedef struct {
    logic        ok;
    logic [63:0] phys;
    logic [63:0] virt;
    logic [22:0] avail;
  } outcome_t;

  typedef struct {
    logic [63:0] addr;
    logic [31:0] size;
  } region_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // req_type, address, size_bytes, target_bytes (from bit 0 up)
  logic [pba_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // ok, phys_addr, virt_addr, available_bytes (from bit 0 up)
  logic [pba_pkg::OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [pba_pkg::CFG_IDX_W-1:0] cfg_idx = pba_pkg::CFG_NONE;
  logic [pba_pkg::CFG_W-1:0] cfg_data = '0;

  // Allocator image kept by the testbench
  bit [0:MAP_PAGES-1] used_pages;
  logic [10:0] next_hint;
  logic [22:0] bytes_left;
  logic [10:0] pool_size;
  logic [63:0] phys_origin;
  logic [63:0] virt_origin;

  outcome_t pending_results[$];
  region_t held_regions[$];
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  page_bitmap_allocator_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned live_pages();
    return (pool_size > MAP_PAGES) ? MAP_PAGES : int'(pool_size);
  endfunction

  function automatic logic [63:0] pool_capacity();
    logic [63:0] c;
    c = 64'(live_pages()) * PG_BYTES;
    return (c > 64'(pba_pkg::AVAIL_MAX)) ? 64'(pba_pkg::AVAIL_MAX) : c;
  endfunction

  function automatic void clear_pool();
    used_pages = '0;
    next_hint = '0;
    bytes_left = 23'(pool_capacity());
  endfunction

  // Next-fit search for n pages in state want; flip the run when found
  function automatic bit claim_run(input logic [63:0] n, input logic [63:0] hint,
                                   input bit want, output int unsigned start);
    int unsigned pages, from, run, i, pass;
    bit found;
    pages = live_pages();
    from = (hint < 64'(pages)) ? int'(hint) : 0;
    found = 1'b0;
    start = 0;
    if (n == 0 || n > 64'(pages)) return 1'b0;
    for (pass = 0; pass < 2 && !found; pass++) begin
      run = 0;
      for (i = (pass == 0) ? from : 0; i < pages && !found; i++) begin
        run = (used_pages[i] == want) ? run + 1 : 0;
        if (64'(run) == n) begin
          start = i + 1 - int'(n);
          found = 1'b1;
        end
      end
    end
    if (!found) return 1'b0;
    for (i = start; i < start + int'(n); i++) used_pages[i] = ~want;
    return 1'b1;
  endfunction

  function automatic void give_back(input logic [63:0] amount);
    logic [63:0] sum;
    sum = 64'(bytes_left) + amount;
    bytes_left = 23'((sum > pool_capacity()) ? pool_capacity() : sum);
  endfunction

  function automatic outcome_t serve_request(input request_t rq);
    outcome_t res;
    int unsigned start;
    logic [63:0] off, change;
    res = '{ok: 1'b0, phys: '0, virt: '0, avail: '0};
    case (rq.kind)
      pba_pkg::REQ_ALLOC: begin
        if (64'(rq.size) <= 64'(bytes_left) &&
            claim_run(64'(rq.size) / PG_BYTES, 64'(next_hint), 1'b0, start)) begin
          off = 64'(start) * PG_BYTES;
          next_hint = 11'(start + rq.size / PG_BYTES);
          bytes_left = bytes_left - 23'(rq.size);
          res.phys = phys_origin + off;
          res.virt = virt_origin + off;
          res.ok = 1'b1;
        end
      end
      pba_pkg::REQ_FREE: begin
        if (claim_run(64'(rq.size) / PG_BYTES, (rq.addr - virt_origin) / PG_BYTES, 1'b1,
                      start)) begin
          next_hint = 11'(start);
          give_back(64'(rq.size));
          res.ok = 1'b1;
        end
      end
      pba_pkg::REQ_SHRINK: begin
        if (rq.target < rq.size) begin
          change = 64'(rq.size) - 64'(rq.target);
          if (claim_run(change / PG_BYTES, (rq.addr - virt_origin + 64'(rq.target)) / PG_BYTES,
                        1'b1, start)) begin
            next_hint = 11'(start);
            give_back(change);
            res.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.avail = bytes_left;
    return res;
  endfunction

  // Offer one item, wait for acceptance, then record its expected result
  task automatic send_request(input request_t rq, output outcome_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, rq.target, rq.size, rq.addr, rq.kind};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    res = serve_request(rq);
    pending_results.push_back(res);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input pba_pkg::cfg_idx_t idx, input logic [63:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_idx <= pba_pkg::CFG_NONE;
    case (idx)
      pba_pkg::CFG_POOL_PAGES: begin
        pool_size = value[10:0];
        clear_pool();
        held_regions.delete();
      end
      pba_pkg::CFG_PHYS_BASE: phys_origin = value;
      pba_pkg::CFG_VIRT_BASE: virt_origin = value;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Issue one request and track regions that stay allocated
  task automatic issue(input pba_pkg::req_t kind, input logic [63:0] addr,
                       input logic [31:0] size, input logic [31:0] target);
    request_t rq;
    outcome_t res;
    rq = '{kind: kind, addr: addr, size: size, target: target};
    send_request(rq, res);
    if (kind == pba_pkg::REQ_ALLOC && res.ok) held_regions.push_back('{addr: res.virt, size: size});
  endtask

  task automatic test_directed_edges();
    write_reg(pba_pkg::CFG_POOL_PAGES, 64'd8);
    write_reg(pba_pkg::CFG_PHYS_BASE, 64'hFFFF_FFFF_FFFF_F000);
    write_reg(pba_pkg::CFG_VIRT_BASE, 64'hFFFF_FFFF_FFFF_E000);
    issue(pba_pkg::REQ_ALLOC, '0, 32'd0, '0);                          // zero pages
    issue(pba_pkg::REQ_ALLOC, '0, 32'd4095, '0);                       // truncates to zero
    issue(pba_pkg::REQ_ALLOC, '0, 32'hFFFF_FFFF, '0);                  // above available
    issue(pba_pkg::REQ_ALLOC, '0, 32'd4096 + 32'd100, '0);             // partial page
    issue(pba_pkg::REQ_ALLOC, '0, 32'd3 * 4096, '0);
    issue(pba_pkg::REQ_ALLOC, '0, 32'd4 * 4096, '0);                   // more than available bytes
    issue(pba_pkg::REQ_ALLOC, '0, 32'd4096, '0);                       // fits at the hint
    issue(pba_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_E000, 32'd8191, '0);   // frees one page, gives back 8191 bytes
    issue(pba_pkg::REQ_ALLOC, '0, 32'd4096, '0);
    issue(pba_pkg::REQ_SHRINK, 64'hFFFF_FFFF_FFFF_F000, 32'd3 * 4096, 32'd3 * 4096); // not smaller
    issue(pba_pkg::REQ_SHRINK, 64'hFFFF_FFFF_FFFF_F000, 32'd3 * 4096, 32'd4096);
    issue(pba_pkg::REQ_FREE, 64'h0, 32'd4096, '0);                     // address below base
    issue(pba_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd4 * 4096, '0);
    issue(pba_pkg::REQ_BAD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(pba_pkg::REQ_SHRINK, '0, 32'd0, 32'hFFFF_FFFF);
    issue(pba_pkg::REQ_FREE, '0, 32'd0, '0);
    issue(pba_pkg::REQ_ALLOC, '0, 32'd8 * 4096, '0);                   // whole pool
    issue(pba_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_E000, 32'd8 * 4096, '0);
  endtask

  // Mostly well-formed alloc/free/shrink traffic, some noise
  task automatic test_random_traffic(input int unsigned count, input logic [10:0] pages);
    int unsigned k, pick, sel, span;
    region_t r;
    logic [31:0] tgt;
    write_reg(pba_pkg::CFG_POOL_PAGES, 64'(pages));
    write_reg(pba_pkg::CFG_PHYS_BASE, rand64());
    write_reg(pba_pkg::CFG_VIRT_BASE, rand64());
    span = (live_pages() / 4 > 1) ? live_pages() / 4 : 1;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50 && held_regions.size() != 0) begin
        sel = $urandom_range(0, held_regions.size() - 1);
        r = held_regions[sel];
        if (pick < 30) begin
          held_regions.delete(sel);
          issue(pba_pkg::REQ_FREE, r.addr, r.size, '0);
        end else begin
          tgt = (r.size > 0) ? $urandom_range(0, r.size - 1) : 32'd0;
          held_regions[sel].size = tgt;
          issue(pba_pkg::REQ_SHRINK, r.addr, r.size, tgt);
        end
      end else if (pick < 88) begin
        issue(pba_pkg::REQ_ALLOC, rand64(),
              32'($urandom_range(1, span)) * 4096 +
              32'($urandom_range(0, 1) * $urandom_range(0, 4095)),
              $urandom);
      end else begin
        issue(pba_pkg::req_t'($urandom_range(0, 3)), rand64(), $urandom, $urandom);
      end
    end
  endtask

  // Hold the receiver off while items keep coming
  task automatic test_backpressure();
    int unsigned k;
    write_reg(pba_pkg::CFG_POOL_PAGES, 64'd16);
    hold_request = 1'b1;
    for (k = 0; k < 6; k++) issue(pba_pkg::REQ_ALLOC, '0, 32'd4096, '0);
    for (k = 0; k < 6; k++) issue(pba_pkg::REQ_FREE, virt_origin + 64'(k) * 4096, 32'd4096, '0);
  endtask

  // Receiver ready pattern
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Compare each result with the oldest expectation; watch for stalls
  always @(posedge clk) begin
    outcome_t exp_res;
    logic got_ok;
    logic [63:0] got_phys, got_virt;
    logic [22:0] got_avail;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL page_bitmap_allocator_unit");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        {got_avail, got_virt, got_phys, got_ok} = m_axis_tdata;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          failures++;
        end else begin
          exp_res = pending_results.pop_front();
          if (got_ok !== exp_res.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, exp_res.ok, got_ok);
            failures++;
          end
          if (got_phys !== exp_res.phys) begin
            $display("%0t: phys_addr expected %h actual %h", $time, exp_res.phys, got_phys);
            failures++;
          end
          if (got_virt !== exp_res.virt) begin
            $display("%0t: virt_addr expected %h actual %h", $time, exp_res.virt, got_virt);
            failures++;
          end
          if (got_avail !== exp_res.avail) begin
            $display("%0t: available_bytes expected %0d actual %0d", $time, exp_res.avail,
                     got_avail);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    pool_size = 11'd1024;
    phys_origin = '0;
    virt_origin = '0;
    clear_pool();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Defaults after reset
    issue(pba_pkg::REQ_ALLOC, '0, 32'd4096 * 3 + 32'd7, '0);
    issue(pba_pkg::REQ_ALLOC, '0, 32'd4194304, '0);
    test_directed_edges();
    test_backpressure();
    test_random_traffic(200, 11'd8);
    test_random_traffic(200, 11'd37);
    test_random_traffic(80, 11'd1024);
    test_random_traffic(60, 11'd2047);
    write_reg(pba_pkg::CFG_PHYS_BASE, 64'd0);
    write_reg(pba_pkg::CFG_VIRT_BASE, 64'd0);
    idle_on = 1'b0;
    test_random_traffic(150, 11'd20);
    drain();
    if (failures == 0) begin
      $display("PASS page_bitmap_allocator_unit");
    end else begin
      $display("FAIL page_bitmap_allocator_unit");
    end
    $finish;
  end
endmodule
